// ----- src/fir_ir_pkg.sv -----
// shared types and constants of the impulse-response fir filter
package fir_ir_pkg;

  // fixed field widths
  localparam int TAP_BITS       = 18;
  localparam int TAP_FRAC       = 16;
  localparam int TAP_INDEX_BITS = 12;
  localparam int TAP_COUNT_BITS = 13;
  localparam int PCM_BITS       = 16;
  localparam int PCM_FULL       = 32767;

  // request kinds on the input channel
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_TAP_WRITE = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_CLAMP = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_ROUND = 7'b1000000
  } state_t;

endpackage

// ----- src/fir_ir_if.sv -----
// channel interfaces of the impulse-response fir filter

// input request: sample or tap write
interface fir_ir_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                                         valid;
  logic                                         ready;
  logic                                         opcode;
  logic        [fir_ir_pkg::TAP_INDEX_BITS-1:0] tap_index;
  logic signed [fir_ir_pkg::TAP_BITS-1:0]       tap_value;
  logic signed [SAMPLE_BITS-1:0]                sample_in;

  modport source (output valid, opcode, tap_index, tap_value, sample_in, input ready);
  modport sink   (input valid, opcode, tap_index, tap_value, sample_in, output ready);
endinterface

// result request: filtered pcm sample
interface fir_ir_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fir_ir_pkg::PCM_BITS-1:0] pcm_out;
  logic                                   clipped;

  modport source (output valid, pcm_out, clipped, input ready);
  modport sink   (input valid, pcm_out, clipped, output ready);
endinterface

// register write: tap count
interface fir_ir_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [fir_ir_pkg::TAP_COUNT_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/fir_ir_ram.sv -----
// generic simple dual-port ram with registered read
module fir_ir_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fir_impulse_response_convolver.sv -----
// top level: direct-form fir filter over a circular delay line in ram
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | opcode, tap_index, tap_value, sample_in
//   out_ch  | out | valid/ready | pcm_out, clipped
//   cfg_ch  | in  | valid/ready | data (tap_count)
//
// a tap write is taken in idle; a sample runs one multiply-accumulate per tap in use
// through the tap and delay rams, then is clamped, scaled and rounded.
// with tap_count zero a sample skips the rams and goes straight to clamping.
// reset clears the pointer, the fill count and tap_count; no clearing pass is run,
// delay entries above the fill count read as zero; tap contents are undefined.
// a waiting result sits in the output register and the next request is still taken.
module fir_impulse_response_convolver #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  fir_ir_in_if.sink      in_ch,
  fir_ir_out_if.source   out_ch,
  fir_ir_cfg_if.sink     cfg_ch
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NW    = $clog2(MAX_TAPS + 1);
  localparam int P_W   = fir_ir_pkg::TAP_BITS + SAMPLE_BITS;
  localparam int ACC_R = P_W + $clog2(MAX_TAPS + 1);
  localparam int ACC_W = (ACC_R > 64) ? 64 : ACC_R;
  localparam int F     = SAMPLE_BITS - 4 + fir_ir_pkg::TAP_FRAC;
  localparam int SW    = F + 16;
  localparam logic [ACC_W-1:0] ONE = {{(ACC_W-1){1'b0}}, 1'b1} << F;
  localparam logic [F-1:0]     HALF = {1'b1, {(F-1){1'b0}}};

  fir_ir_pkg::state_t state_r, state_nxt;

  logic [fir_ir_pkg::TAP_COUNT_BITS-1:0] tap_count_r;
  logic [NW-1:0]                         n_r, n_nxt;
  logic [NW-1:0]                         fill_r, fill_nxt;
  logic [AW-1:0]                         wp_r, wp_nxt;
  logic [AW-1:0]                         wp_eff;
  logic [AW-1:0]                         idx_r, idx_nxt;
  logic [AW-1:0]                         k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0]         x_r, x_nxt;
  logic                                  rd_vld_r, rd_vld_nxt;
  logic                                  dl_ok_r, dl_ok_nxt;
  logic                                  mul_vld_r;
  logic signed [P_W-1:0]                 prod_r;
  logic signed [ACC_W-1:0]               acc_r, acc_nxt;
  logic                                  neg_r, neg_nxt;
  logic                                  clip_r, clip_nxt;
  logic [F:0]                            mag_r, mag_nxt;
  logic [SW-1:0]                         scl_r;
  logic                                  out_vld_r, out_vld_nxt;
  logic signed [fir_ir_pkg::PCM_BITS-1:0] pcm_r, pcm_nxt;
  logic                                  clipped_r, clipped_nxt;

  logic                                  in_acc;
  logic                                  tap_we;
  logic                                  dl_we;
  logic [fir_ir_pkg::TAP_BITS-1:0]       tap_rdata;
  logic [SAMPLE_BITS-1:0]                dl_rdata;
  logic signed [fir_ir_pkg::TAP_BITS-1:0] tap_s;
  logic signed [SAMPLE_BITS-1:0]         dl_s;
  logic [ACC_W-1:0]                      mag_full;
  logic [15:0]                           q;
  logic [F-1:0]                          rem;
  logic [15:0]                           q_rnd;
  logic                                  out_load;

  // handshakes
  assign in_ch.ready  = (state_r == fir_ir_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.pcm_out = pcm_r;
  assign out_ch.clipped = clipped_r;
  assign out_load = (state_r == fir_ir_pkg::ST_ROUND) && (!out_vld_r || out_ch.ready);

  // tap store
  assign tap_we = in_acc && (in_ch.opcode == fir_ir_pkg::OP_TAP_WRITE)
                  && (32'(in_ch.tap_index) < MAX_TAPS);

  fir_ir_ram #(
    .WIDTH (fir_ir_pkg::TAP_BITS),
    .DEPTH (MAX_TAPS),
    .ADDR_W(AW)
  ) u_tap_ram (
    .clk  (clk),
    .we   (tap_we),
    .waddr(AW'(in_ch.tap_index)),
    .wdata(in_ch.tap_value),
    .raddr(k_r),
    .rdata(tap_rdata)
  );

  // delay line, written once per sample before its taps are read
  assign dl_we  = (state_r == fir_ir_pkg::ST_LOAD);
  assign wp_eff = (32'(wp_r) >= 32'(n_r)) ? '0 : wp_r;

  fir_ir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS),
    .ADDR_W(AW)
  ) u_dl_ram (
    .clk  (clk),
    .we   (dl_we),
    .waddr(wp_eff),
    .wdata(x_r),
    .raddr(idx_r),
    .rdata(dl_rdata)
  );

  // read data, never-written delay entries as zero
  assign tap_s = tap_rdata;
  assign dl_s  = dl_ok_r ? dl_rdata : '0;

  // clamp and rounding arithmetic
  assign mag_full = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign q        = scl_r[SW-1:F];
  assign rem      = scl_r[F-1:0];
  assign q_rnd    = ((rem > HALF) || ((rem == HALF) && q[0])) ? q + 16'd1 : q;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    fill_nxt    = fill_r;
    wp_nxt      = wp_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    x_nxt       = x_r;
    rd_vld_nxt  = 1'b0;
    dl_ok_nxt   = dl_ok_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    clip_nxt    = clip_r;
    mag_nxt     = mag_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    pcm_nxt     = pcm_r;
    clipped_nxt = clipped_r;
    if (mul_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
    case (state_r)
      fir_ir_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.opcode == fir_ir_pkg::OP_SAMPLE)) begin
          x_nxt = in_ch.sample_in;
          n_nxt = (32'(tap_count_r) > MAX_TAPS) ? NW'(MAX_TAPS) : NW'(tap_count_r);
          if (32'(tap_count_r) == 0) begin
            acc_nxt   = ACC_W'(in_ch.sample_in) <<< fir_ir_pkg::TAP_FRAC;
            state_nxt = fir_ir_pkg::ST_CLAMP;
          end else begin
            state_nxt = fir_ir_pkg::ST_LOAD;
          end
        end
      end
      fir_ir_pkg::ST_LOAD: begin
        acc_nxt = '0;
        idx_nxt = wp_eff;
        k_nxt   = '0;
        wp_nxt  = (32'(wp_eff) + 1 >= 32'(n_r)) ? '0 : wp_eff + AW'(1);
        if (32'(wp_eff) + 1 > 32'(fill_r)) begin
          fill_nxt = NW'(32'(wp_eff) + 1);
        end
        state_nxt = fir_ir_pkg::ST_MAC;
      end
      fir_ir_pkg::ST_MAC: begin
        rd_vld_nxt = 1'b1;
        dl_ok_nxt  = 32'(idx_r) < 32'(fill_r);
        idx_nxt    = (idx_r == '0) ? AW'(n_r - NW'(1)) : idx_r - AW'(1);
        k_nxt      = k_r + AW'(1);
        if (32'(k_r) + 1 == 32'(n_r)) begin
          state_nxt = fir_ir_pkg::ST_DRAIN;
        end
      end
      fir_ir_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !mul_vld_r) begin
          state_nxt = fir_ir_pkg::ST_CLAMP;
        end
      end
      fir_ir_pkg::ST_CLAMP: begin
        neg_nxt   = acc_r[ACC_W-1];
        clip_nxt  = mag_full > ONE;
        mag_nxt   = (mag_full > ONE) ? ONE[F:0] : mag_full[F:0];
        state_nxt = fir_ir_pkg::ST_SCALE;
      end
      fir_ir_pkg::ST_SCALE: begin
        state_nxt = fir_ir_pkg::ST_ROUND;
      end
      fir_ir_pkg::ST_ROUND: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          pcm_nxt     = neg_r ? -$signed(q_rnd) : $signed(q_rnd);
          clipped_nxt = clip_r;
          state_nxt   = fir_ir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir_ir_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fir_ir_pkg::ST_IDLE;
      tap_count_r <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      wp_r      <= wp_nxt;
      rd_vld_r  <= rd_vld_nxt;
      mul_vld_r <= rd_vld_r;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tap_count_r <= cfg_ch.data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    x_r       <= x_nxt;
    dl_ok_r   <= dl_ok_nxt;
    prod_r    <= tap_s * dl_s;
    acc_r     <= acc_nxt;
    neg_r     <= neg_nxt;
    clip_r    <= clip_nxt;
    mag_r     <= mag_nxt;
    scl_r     <= {mag_r, 15'b0} - SW'(mag_r);
    pcm_r     <= pcm_nxt;
    clipped_r <= clipped_nxt;
  end

`ifndef SYNTH
  // no request taken while products are still in flight
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r || mul_vld_r) |-> !in_ch.ready)
    else $error("request accepted during accumulation");

  // delay reads stay inside the taps in use
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_ir_pkg::ST_MAC) |-> (32'(idx_r) < 32'(n_r)))
    else $error("delay index beyond tap count");

  // pointer wraps inside the taps in use
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_ir_pkg::ST_LOAD) |=> (32'(wp_r) < 32'(n_r)))
    else $error("write pointer beyond tap count");

  // the sum is complete when clamping starts
  a_clamp_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_ir_pkg::ST_CLAMP) |-> (!rd_vld_r && !mul_vld_r))
    else $error("clamp before accumulation finished");

  // a finished result reaches the output register
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_vld_r && (state_r == fir_ir_pkg::ST_IDLE)))
    else $error("result not presented");
`endif

endmodule
